>>> hw/rtl/macs_pkg.sv
package macs_pkg;

  typedef enum logic [1:0] {
    DEC_NONE = 2'd0,
    DEC_BUY  = 2'd1,
    DEC_SELL = 2'd2
  } decision_t;

  localparam int unsigned TICK_BITS  = 32;
  localparam int unsigned DPRICE_BITS = 32;

endpackage

>>> hw/rtl/moving_average_crossover_signal.sv
// Moving-average crossover signal. Each accepted tick_price request gives exactly one result:
// decision is buy when the price falls to at-or-below the mean of the last WINDOW prices,
// sell when it rises above it, and no action otherwise or before WINDOW ticks have arrived
// (decision_price is the tick's price on buy or sell, else zero). Only the low PRICE_BITS
// bits of tick_price are used. It takes one request every cycle unless the output stalls;
// results pass stages 1 and 2 and the output register. The price ring, a single memory with
// one read-first port per cycle, sets the rate: the slot being overwritten is read out in
// the same cycle it is written, and the running sum is updated as the tick leaves stage 1.
// The ring needs no clearing after reset, so requests are accepted from the first cycle.
// Stalls on the result side hold the pipeline; in_ready drops only when every stage is full.
module moving_average_crossover_signal
  import macs_pkg::*;
#(
  parameter int unsigned WINDOW     = 50,
  parameter int unsigned PRICE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [TICK_BITS-1:0]   tick_price,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             decision,
  output logic [DPRICE_BITS-1:0] decision_price
);

  localparam int unsigned CW   = $clog2(WINDOW + 1);
  localparam int unsigned PW   = $clog2(WINDOW);
  localparam int unsigned SW   = PRICE_BITS + CW;
  localparam int unsigned EXT  = (PRICE_BITS > TICK_BITS) ? PRICE_BITS : TICK_BITS;
  localparam int unsigned EXTO = (PRICE_BITS > DPRICE_BITS) ? PRICE_BITS : DPRICE_BITS;

  // price ring
  logic [PRICE_BITS-1:0] ring [WINDOW];

  logic [PW-1:0] ptr;
  logic [CW-1:0] fill;
  logic [SW-1:0] running_sum;
  logic          last_was_above;

  // stage 1: tick accepted, old slot value read
  logic                  s1_v;
  logic [PRICE_BITS-1:0] s1_price;
  logic [PRICE_BITS-1:0] s1_old;
  logic                  s1_was_full;
  logic                  s1_full;
  logic [CW-1:0]         s1_fill;

  // stage 2: sum updated, product registered
  logic                  s2_v;
  logic [PRICE_BITS-1:0] s2_price;
  logic                  s2_full;
  logic [SW-1:0]         s2_prod;

  logic                  accept, s1_go, s2_go, s1_free, s2_free, out_free;
  logic [EXT-1:0]        tick_ext;
  logic [PRICE_BITS-1:0] price_in;
  logic [CW-1:0]         fill_next;
  logic [PW-1:0]         ptr_next;
  logic [SW-1:0]         sum_next;
  logic                  above;
  logic [EXTO-1:0]       dprice_ext;
  decision_t             dec_next;

  assign out_free = !out_valid || out_ready;
  assign s2_go    = s2_v && out_free;
  assign s2_free  = !s2_v || s2_go;
  assign s1_go    = s1_v && s2_free;
  assign s1_free  = !s1_v || s1_go;
  assign in_ready = s1_free;
  assign accept   = in_valid && in_ready;

  assign tick_ext = EXT'(tick_price);
  assign price_in = tick_ext[PRICE_BITS-1:0];

  assign fill_next = (fill < CW'(WINDOW)) ? fill + CW'(1) : fill;
  assign ptr_next  = (ptr == PW'(WINDOW - 1)) ? '0 : ptr + PW'(1);

  // read-first: the old price of the slot comes out as the new one goes in
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_old    <= ring[ptr];
      ring[ptr] <= price_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      ptr  <= '0;
      fill <= '0;
    end else begin
      if (accept) begin
        s1_v <= 1'b1;
        ptr  <= ptr_next;
        fill <= fill_next;
      end else if (s1_go) begin
        s1_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_price    <= price_in;
      s1_was_full <= (fill >= CW'(WINDOW));
      s1_full     <= (fill_next >= CW'(WINDOW));
      s1_fill     <= fill_next;
    end
  end

  assign sum_next = s1_was_full ? running_sum + SW'(s1_price) - SW'(s1_old)
                                : running_sum + SW'(s1_price);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v        <= 1'b0;
      running_sum <= '0;
    end else begin
      if (s1_go) begin
        running_sum <= sum_next;
        s2_v        <= 1'b1;
      end else if (s2_go) begin
        s2_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_price <= s1_price;
      s2_full  <= s1_full;
      s2_prod  <= SW'(s1_price) * SW'(s1_fill);
    end
  end

  // running_sum already holds the sum that includes the stage 2 tick
  assign above      = s2_prod > running_sum;
  assign dprice_ext = EXTO'(s2_price);

  always_comb begin
    dec_next = DEC_NONE;
    if (s2_full && (above != last_was_above)) begin
      dec_next = above ? DEC_SELL : DEC_BUY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      last_was_above <= 1'b0;
    end else begin
      if (s2_go) begin
        out_valid      <= 1'b1;
        last_was_above <= above;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      decision       <= dec_next;
      decision_price <= (dec_next == DEC_NONE) ? '0 : dprice_ext[DPRICE_BITS-1:0];
    end
  end

endmodule

>>> tb/sv/moving_average_crossover_signal_tb.sv
`timescale 1ns / 100ps

module moving_average_crossover_signal_tb;
  import macs_pkg::*;

  localparam int unsigned WINDOW = 50;
  localparam int unsigned PRICE_BITS = 32;
  localparam logic [63:0] PRICE_MASK = (64'd1 << PRICE_BITS) - 64'd1;
  localparam longint PRICE_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int unsigned EXPECT_DEPTH = 64;

  typedef struct packed {
    decision_t action;
    logic [31:0] price;
  } crossover_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [TICK_BITS-1:0] tick_price;
  logic out_valid;
  logic out_ready;
  logic [1:0] decision;
  logic [DPRICE_BITS-1:0] decision_price;

  // shadow of the block state
  logic [63:0] price_hist [WINDOW];
  logic [63:0] window_sum;
  int unsigned ticks_seen;
  int unsigned wr_slot;
  logic prev_above;

  // expected results in request order
  crossover_t expected_ring [EXPECT_DEPTH];
  int unsigned expect_wr;
  int unsigned expect_rd;
  int unsigned mismatch_count;
  int stall_cycles;
  bit idle_on;

  moving_average_crossover_signal #(
    .WINDOW(WINDOW),
    .PRICE_BITS(PRICE_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .tick_price(tick_price),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .decision(decision),
    .decision_price(decision_price)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic crossover_t predict_crossover(logic [31:0] tick);
    logic [63:0] p;
    logic above;
    crossover_t res;
    p = {32'b0, tick} & PRICE_MASK;
    if (ticks_seen >= WINDOW) begin
      window_sum = window_sum + p - price_hist[wr_slot];
    end else begin
      window_sum = window_sum + p;
      ticks_seen++;
    end
    price_hist[wr_slot] = p;
    wr_slot = (wr_slot + 1 >= WINDOW) ? 0 : wr_slot + 1;
    // price above mean without a divide
    above = (p * 64'(ticks_seen)) > window_sum;
    res.action = DEC_NONE;
    res.price = '0;
    if (ticks_seen >= WINDOW && above != prev_above) begin
      res.action = above ? DEC_SELL : DEC_BUY;
      res.price = p[31:0];
    end
    prev_above = above;
    return res;
  endfunction

  // price near the mean of the window that the next tick completes
  function automatic logic [31:0] mean_edge_price(int delta);
    logic [63:0] rest;
    longint q;
    if (ticks_seen < WINDOW) begin
      return $urandom;
    end
    rest = window_sum - price_hist[wr_slot];
    q = longint'(rest / (WINDOW - 1)) + delta;
    if (q < 0) q = 0;
    if (q > PRICE_MAX) q = PRICE_MAX;
    return q[31:0];
  endfunction

  function automatic logic [31:0] random_tick();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return mean_edge_price($signed($urandom_range(0, 6)) - 3);
    if (pick < 70) return mean_edge_price($urandom_range(0, 1));
    if (pick < 85) return $urandom;
    if (pick < 90) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom >> $urandom_range(0, 31);
  endfunction

  task automatic send_tick(logic [31:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick_price <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_ring[expect_wr % EXPECT_DEPTH] = predict_crossover(value);
    expect_wr++;
  endtask

  task automatic hold_until_settled();
    in_valid <= 1'b0;
    while (expect_wr != expect_rd) @(posedge clk);
  endtask

  task automatic test_fill_extremes();
    logic [31:0] pattern [16];
    pattern = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_0100,
                32'h0100_0000, 32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0};
    idle_on = 1'b1;
    foreach (pattern[i]) send_tick(pattern[i]);
  endtask

  // last fill tick at-or-below, first full tick above, then back down
  task automatic test_first_full_tick();
    while (ticks_seen < WINDOW - 2) send_tick($urandom);
    send_tick(32'h0);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'h0);
  endtask

  task automatic test_equal_mean();
    logic [31:0] level;
    level = 32'h1234_5678;
    repeat (WINDOW) send_tick(level);
    send_tick(level + 1);
    send_tick(level);
    send_tick(mean_edge_price(0));
    send_tick(mean_edge_price(1));
  endtask

  task automatic test_random_ticks(int count, bit with_idle);
    idle_on = with_idle;
    repeat (count) send_tick(random_tick());
  endtask

  task automatic test_drain_pause();
    idle_on = 1'b1;
    repeat (100) send_tick(random_tick());
    hold_until_settled();
    repeat (100) send_tick(random_tick());
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    tick_price <= '0;
    idle_on = 1'b1;
    mismatch_count = 0;
    expect_wr = 0;
    expect_rd = 0;
    window_sum = '0;
    ticks_seen = 0;
    wr_slot = 0;
    prev_above = 1'b0;
    foreach (price_hist[i]) price_hist[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_fill_extremes();
    test_first_full_tick();
    test_equal_mean();
    test_random_ticks(500, 1'b1);
    test_drain_pause();
    test_random_ticks(300, 1'b0);
    test_random_ticks(500, 1'b1);
    test_random_ticks(400, 1'b0);
    hold_until_settled();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side: random stall bursts while idling is on
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    crossover_t want;
    if (!rst && out_valid && out_ready) begin
      if (expect_wr == expect_rd) begin
        $display("%0t unexpected result: decision %0d price %0h", $time, decision,
                 decision_price);
        mismatch_count++;
      end else begin
        want = expected_ring[expect_rd % EXPECT_DEPTH];
        expect_rd++;
        if (decision !== want.action) begin
          $display("%0t decision mismatch: expected %0d actual %0d", $time, want.action,
                   decision);
          mismatch_count++;
        end
        if (decision_price !== want.price) begin
          $display("%0t decision_price mismatch: expected %0h actual %0h", $time,
                   want.price, decision_price);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t no request or result moved for %0d cycles", $time, stall_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

>>> moving_average_crossover_signal.f
hw/rtl/macs_pkg.sv
hw/rtl/moving_average_crossover_signal.sv
tb/sv/moving_average_crossover_signal_tb.sv
